/* rtl/pfe_pkg.sv */
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int DIV_CNT_W   = $clog2(VALUE_W);

  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2b;
  localparam logic [7:0] SYM_MINUS = 8'h2d;
  localparam logic [7:0] SYM_STAR  = 8'h2a;
  localparam logic [7:0] SYM_SLASH = 8'h2f;

  localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      bad_symbol_seen;
    logic                      divide_by_zero_seen;
    logic                      overflow_seen;
  } out_t;

  // Micro-operations that one control word asks of the datapath.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_DIGIT,
    ACT_POP1,
    ACT_POP2,
    ACT_LOAD_V2,
    ACT_ALU,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_DIV_FIX,
    ACT_PUSH,
    ACT_LOAD_TOP,
    ACT_EMIT,
    ACT_BAD
  } act_t;

  // Jump conditions; the jump is taken when the condition holds.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_DIGIT,
    C_BAD,
    C_DIV,
    C_DIV_ZERO,
    C_DIV_MORE,
    C_NOT_LAST,
    C_OUT_FREE
  } cond_t;

  typedef logic [3:0] uaddr_t;

  typedef struct packed {
    act_t   act;
    cond_t  cond;
    uaddr_t target;
  } uword_t;

  localparam uaddr_t UA_FETCH    = 4'd0;
  localparam uaddr_t UA_DISPATCH = 4'd1;
  localparam uaddr_t UA_POP1     = 4'd2;
  localparam uaddr_t UA_POP2     = 4'd3;
  localparam uaddr_t UA_LOAD_V2  = 4'd4;
  localparam uaddr_t UA_ALU      = 4'd5;
  localparam uaddr_t UA_DIV_INIT = 4'd6;
  localparam uaddr_t UA_DIV_STEP = 4'd7;
  localparam uaddr_t UA_DIV_FIX  = 4'd8;
  localparam uaddr_t UA_PUSH     = 4'd9;
  localparam uaddr_t UA_FINISH   = 4'd10;
  localparam uaddr_t UA_LOAD_TOP = 4'd11;
  localparam uaddr_t UA_EMIT     = 4'd12;
  localparam uaddr_t UA_EMIT_WT  = 4'd13;
  localparam uaddr_t UA_BAD      = 4'd14;
  localparam uaddr_t UA_BAD_END  = 4'd15;

  function automatic uword_t ucode(input uaddr_t addr);
    uword_t w;
    w = '{act: ACT_NONE, cond: C_ALWAYS, target: UA_FETCH};
    case (addr)
      UA_FETCH:    w = '{act: ACT_NONE,     cond: C_NO_INPUT, target: UA_FETCH};
      UA_DISPATCH: w = '{act: ACT_DIGIT,    cond: C_DIGIT,    target: UA_PUSH};
      UA_POP1:     w = '{act: ACT_POP1,     cond: C_NEVER,    target: UA_FETCH};
      UA_POP2:     w = '{act: ACT_POP2,     cond: C_BAD,      target: UA_BAD};
      UA_LOAD_V2:  w = '{act: ACT_LOAD_V2,  cond: C_DIV,      target: UA_DIV_INIT};
      UA_ALU:      w = '{act: ACT_ALU,      cond: C_ALWAYS,   target: UA_PUSH};
      UA_DIV_INIT: w = '{act: ACT_DIV_INIT, cond: C_DIV_ZERO, target: UA_PUSH};
      UA_DIV_STEP: w = '{act: ACT_DIV_STEP, cond: C_DIV_MORE, target: UA_DIV_STEP};
      UA_DIV_FIX:  w = '{act: ACT_DIV_FIX,  cond: C_NEVER,    target: UA_FETCH};
      UA_PUSH:     w = '{act: ACT_PUSH,     cond: C_NOT_LAST, target: UA_FETCH};
      UA_FINISH:   w = '{act: ACT_POP1,     cond: C_NEVER,    target: UA_FETCH};
      UA_LOAD_TOP: w = '{act: ACT_LOAD_TOP, cond: C_NEVER,    target: UA_FETCH};
      UA_EMIT:     w = '{act: ACT_EMIT,     cond: C_OUT_FREE, target: UA_FETCH};
      UA_EMIT_WT:  w = '{act: ACT_NONE,     cond: C_ALWAYS,   target: UA_EMIT};
      UA_BAD:      w = '{act: ACT_BAD,      cond: C_NOT_LAST, target: UA_FETCH};
      UA_BAD_END:  w = '{act: ACT_NONE,     cond: C_ALWAYS,   target: UA_FINISH};
      default:     w = '{act: ACT_NONE,     cond: C_ALWAYS,   target: UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* rtl/pfe_ram.sv */
`timescale 1ns / 1ps

module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/postfix_expression_evaluator_core.sv */
`timescale 1ns / 1ps

// Postfix expression evaluator. One character of the expression is taken per
// transfer on the input channel; a result comes out only after the character
// marked last, carrying the popped top of the stack (-1 when empty) and the
// sticky flags for the whole expression, after which stack and flags clear.
// A small microprogram steps a shared datapath around a simple dual-port
// value stack RAM (one write port, one read port), one item at a time; a
// division runs through the one-bit-per-cycle restoring divider, or pushes
// zero without dividing when the divisor is zero. The item marked last is
// followed by a final pop and a write of the output register, which waits
// while the output is stalled.
module postfix_expression_evaluator_core
  import pfe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  uaddr_t pc;
  uaddr_t pc_next;
  uword_t uw;
  logic   take;

  logic [7:0]          sym;
  logic                last_r;
  logic [COUNT_W-1:0]  count;
  logic                pop_empty;
  logic [VALUE_W-1:0]  v1;
  logic [VALUE_W-1:0]  v2;
  logic [VALUE_W-1:0]  result;
  logic                bad_flag;
  logic                dbz_flag;
  logic                ovf_flag;

  logic [VALUE_W-1:0]   quo;
  logic [VALUE_W-1:0]   rem;
  logic [VALUE_W-1:0]   dvs;
  logic                 q_neg;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                in_fire;
  logic                out_free;
  logic                emit_fire;
  logic                is_digit;
  logic                is_op;
  logic [ADDR_W-1:0]   rd_addr;
  logic [VALUE_W-1:0]  rd_data;
  logic                wr_en;
  logic                stack_full;
  logic [VALUE_W-1:0]  pop_value;
  logic [VALUE_W:0]    rem_sh;
  logic [VALUE_W:0]    trial;

  assign uw        = ucode(pc);
  assign in_stall  = (pc != UA_FETCH);
  assign in_fire   = in_valid && (pc == UA_FETCH);
  assign out_free  = !out_valid || !out_stall;
  assign emit_fire = (uw.act == ACT_EMIT) && out_free;

  always_comb begin
    is_digit = (sym inside {[SYM_ZERO:SYM_NINE]});
    is_op    = (sym inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH});
  end

  always_comb begin
    case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !in_valid;
      C_DIGIT:    take = is_digit;
      C_BAD:      take = !is_op;
      C_DIV:      take = (sym == SYM_SLASH);
      C_DIV_ZERO: take = (v1 == '0);
      C_DIV_MORE: take = (div_cnt != '0);
      C_NOT_LAST: take = !last_r;
      C_OUT_FREE: take = out_free;
      default:    take = 1'b0;
    endcase
    pc_next = take ? uw.target : pc + 4'd1;
  end

  // The RAM always reads the current top; its data is registered and lands in the next cycle.
  assign rd_addr    = ADDR_W'(count - COUNT_W'(1));
  assign stack_full = (count == COUNT_W'(STACK_DEPTH));
  assign wr_en      = (uw.act == ACT_PUSH) && !stack_full;
  assign pop_value  = pop_empty ? EMPTY_VALUE : rd_data;

  pfe_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[ADDR_W-1:0]),
    .wdata(result),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign rem_sh = {rem, quo[VALUE_W-1]};
  assign trial  = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= UA_FETCH;
      count     <= '0;
      bad_flag  <= 1'b0;
      dbz_flag  <= 1'b0;
      ovf_flag  <= 1'b0;
      out_valid <= 1'b0;
      pop_empty <= 1'b0;
    end else begin
      pc        <= pc_next;
      out_valid <= emit_fire || (out_valid && out_stall);
      case (uw.act)
        ACT_POP1, ACT_POP2: begin
          pop_empty <= (count == '0);
          if (count != '0) begin
            count <= count - COUNT_W'(1);
          end
        end
        ACT_DIV_INIT: begin
          if (v1 == '0) begin
            dbz_flag <= 1'b1;
          end
        end
        ACT_PUSH: begin
          if (stack_full) begin
            ovf_flag <= 1'b1;
          end else begin
            count <= count + COUNT_W'(1);
          end
        end
        ACT_BAD: begin
          bad_flag <= 1'b1;
        end
        ACT_EMIT: begin
          if (out_free) begin
            count    <= '0;
            bad_flag <= 1'b0;
            dbz_flag <= 1'b0;
            ovf_flag <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sym    <= in_data.symbol;
      last_r <= in_data.last;
    end
    case (uw.act)
      ACT_DIGIT: begin
        result <= VALUE_W'(sym - SYM_ZERO);
      end
      ACT_POP2, ACT_LOAD_TOP: begin
        v1 <= pop_value;
      end
      ACT_LOAD_V2: begin
        v2 <= pop_value;
      end
      ACT_ALU: begin
        case (sym)
          SYM_PLUS:  result <= v2 + v1;
          SYM_MINUS: result <= v2 - v1;
          default:   result <= v2 * v1;
        endcase
      end
      ACT_DIV_INIT: begin
        result  <= '0;
        quo     <= v2[VALUE_W-1] ? -v2 : v2;
        dvs     <= v1[VALUE_W-1] ? -v1 : v1;
        rem     <= '0;
        q_neg   <= v2[VALUE_W-1] ^ v1[VALUE_W-1];
        div_cnt <= DIV_CNT_W'(VALUE_W - 1);
      end
      ACT_DIV_STEP: begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
        if (!trial[VALUE_W]) begin
          rem <= trial[VALUE_W-1:0];
          quo <= {quo[VALUE_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[VALUE_W-1:0];
          quo <= {quo[VALUE_W-2:0], 1'b0};
        end
      end
      ACT_DIV_FIX: begin
        result <= q_neg ? -quo : quo;
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_data.value               <= v1;
          out_data.bad_symbol_seen     <= bad_flag;
          out_data.divide_by_zero_seen <= dbz_flag;
          out_data.overflow_seen       <= ovf_flag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
